@@ rtl/core/ess_pkg.sv @@
// Package for the eased segment scheduler core: widths, command codes and
// the table entry type, and the request and response types. Depends on nothing.
`default_nettype none
package ess_pkg;
   localparam int MaxSegments = 16;
   localparam int IdxBits     = 4;
   localparam int CntBits     = 5;
   localparam int TimeBits    = 32;
   localparam int QBits       = 17;
   localparam logic [QBits-1:0] QOne = 17'h10000;

   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   typedef struct packed {
      logic [TimeBits-1:0] duration;
      logic [7:0]          repeats;
      logic [QBits-1:0]    ease_in;
      logic [QBits-1:0]    ease_out;
      logic                moves;
   } entry_type;

   typedef struct packed {
      logic [1:0]          cmd;
      logic [TimeBits-1:0] time_now;
      logic [IdxBits-1:0]  entry_index;
      logic [TimeBits-1:0] entry_duration;
      logic [7:0]          entry_repeats;
      logic [QBits-1:0]    entry_ease_in;
      logic [QBits-1:0]    entry_ease_out;
      logic                entry_moves;
   } req_type;

   typedef struct packed {
      logic [CntBits-1:0] segment_index;
      logic [QBits-1:0]   progress;
      logic               active;
      logic               finished;
   } rsp_type;
endpackage
`default_nettype wire

@@ rtl/core/ess_if.sv @@
// Valid/ready channel interfaces for requests, responses and the register
// write port. Depends on ess_pkg.
`default_nettype none
interface ess_req_if;
   logic valid;
   logic ready;
   ess_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ess_rsp_if;
   logic valid;
   logic ready;
   ess_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface ess_csr_if;
   logic valid;
   logic ready;
   logic [ess_pkg::CntBits-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/eased_segment_scheduler_core.sv @@
// Eased segment scheduler core. Depends on ess_pkg, ess_if, ess_serial_mul.
//
// A request is a load, a start or a tick, and each one gives exactly one
// response. The response to a load or a start is registered through the
// S_OUT state after the request is taken. A tick first walks the segment
// table to retire ended segments, through S_WALK and S_MW for each retired
// segment. For a moving segment it then runs these steps in order:
//   - a bit-serial multiply for elapsed*(repeats+1)
//   - a 32-step restoring remainder
//   - a 16-step fraction division
//   - six serial multiplies for the Bezier ease
// The length of each serial multiply follows the number of significant
// bits of its second operand. The worst case for a tick is 15 retired
// segments and 256 repeats, then the remainder, the division and the
// multiplies. The serial multiplier and the one-bit-a-cycle divider set
// how long a tick takes. One request is in work at a time. A new request
// is taken only once the held response has been accepted.
`default_nettype none
module eased_segment_scheduler_core (
   input wire logic clock,
   input wire logic reset,
   ess_req_if.sink   req,
   ess_rsp_if.source rsp,
   ess_csr_if.sink   csr
);
   import ess_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0, S_WALK = 4'd1, S_REP = 4'd2,
      S_MOD = 4'd3, S_FRAC = 4'd4, S_M1 = 4'd5, S_M2 = 4'd6, S_M3 = 4'd7,
      S_M4 = 4'd8, S_M5 = 4'd9, S_OUT = 4'd10, S_MW = 4'd11, S_M6 = 4'd12,
      S_MUL = 4'd13;

   entry_type table_mem [MaxSegments];
   entry_type ent_ff;

   logic [3:0]          state_ff, state_in, ret_ff, ret_in;
   logic [CntBits-1:0]  count_ff, count_in, cur_ff, cur_in;
   logic [TimeBits-1:0] start_ff, start_in, now_ff, now_in;
   logic [5:0]          step_ff, step_in;
   logic [63:0]         r_ff, r_in, d_ff, d_in, q_ff, q_in, x_ff, x_in;
   logic [16:0]         t_ff, t_in;
   logic                act_ff, act_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;
   logic                mstart;
   logic [63:0]         ma, mb;
   logic                mdone;
   logic [63:0]         mprod;
   logic [CntBits-1:0]  eff_count;
   logic [TimeBits-1:0] end_time;
   logic [64:0]         rsh;

   ess_serial_mul u_mul (
      .clock(clock), .reset(reset), .start(mstart), .op_a(ma), .op_b(mb),
      .done(mdone), .product(mprod)
   );

   assign eff_count = (count_ff > CntBits'(MaxSegments)) ? CntBits'(MaxSegments) : count_ff;
   assign end_time  = start_ff + ent_ff.duration;
   assign rsh       = {r_ff, 1'b0};
   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign csr.ready = 1'b1;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

   always_comb begin
      state_in = state_ff; ret_in = ret_ff; count_in = count_ff; cur_in = cur_ff;
      start_in = start_ff; now_in = now_ff; step_in = step_ff;
      r_in = r_ff; d_in = d_ff; q_in = q_ff; x_in = x_ff; t_in = t_ff;
      act_in = act_ff; rsp_valid_in = rsp_valid_ff; rsp_in = rsp_ff;
      mstart = 1'b0; ma = '0; mb = '0;
      if (rsp.valid && rsp.ready) rsp_valid_in = 1'b0;
      if (csr.valid) count_in = csr.data;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               now_in = req.data.time_now;
               act_in = 1'b0;
               t_in = '0;
               state_in = S_OUT;
               if (req.data.cmd == CMD_START) begin
                  cur_in = '0; start_in = req.data.time_now;
               end else if (req.data.cmd == CMD_TICK && cur_ff < eff_count) begin
                  state_in = S_WALK;
               end
            end
         end
         S_WALK: begin
            // ent_ff holds the entry of cur_ff here
            if (cur_ff >= eff_count) begin
               state_in = S_OUT;
            end else if (now_ff >= end_time) begin
               cur_in = cur_ff + 1'b1;
               if (cur_ff + 1'b1 < eff_count) start_in = end_time;
               state_in = S_MW;
            end else if (ent_ff.moves) begin
               act_in = 1'b1;
               mstart = 1'b1;
               ma = 64'(now_ff - start_ff);
               mb = 64'({1'b0, ent_ff.repeats} + 9'd1);
               ret_in = S_REP; state_in = S_MUL;
            end else begin
               state_in = S_OUT;
            end
         end
         S_MW: state_in = S_WALK;
         S_REP: begin
            // the product is held; begin the remainder
            d_in = 64'(ent_ff.duration);
            r_in = '0;
            x_in = {32'(mprod), 32'd0};
            step_in = 6'd32;
            if (ent_ff.duration == '0) begin
               t_in = '0; state_in = S_M1;
            end else state_in = S_MOD;
         end
         S_MOD: begin
            r_in = {r_ff[62:0], x_ff[63]};
            x_in = x_ff << 1;
            if ({r_ff[62:0], x_ff[63]} >= d_ff) r_in = {r_ff[62:0], x_ff[63]} - d_ff;
            step_in = step_ff - 1'b1;
            if (step_ff == 6'd1) begin
               step_in = 6'd16; q_in = '0; state_in = S_FRAC;
            end
         end
         S_FRAC: begin
            q_in = q_ff << 1;
            r_in = rsh[63:0];
            if (rsh[64] || rsh[63:0] >= d_ff) begin
               r_in = rsh[63:0] - d_ff; q_in = (q_ff << 1) | 64'd1;
            end
            step_in = step_ff - 1'b1;
            if (step_ff == 6'd1) begin
               t_in = 17'(q_in[15:0]); state_in = S_M1;
            end
         end
         S_M1: begin
            // a*mt
            mstart = 1'b1; ma = 64'(ent_ff.ease_in); mb = 64'(QOne - t_ff);
            ret_in = S_M2; state_in = S_MUL;
         end
         S_M2: begin
            // keep a*mt, start b*t
            x_in = mprod;
            mstart = 1'b1; ma = 64'(QOne - ent_ff.ease_out); mb = 64'(t_ff);
            ret_in = S_M3; state_in = S_MUL;
         end
         S_M3: begin
            // lin*(mt*t): first mt*t
            q_in = 64'd3 * (x_ff + mprod);
            mstart = 1'b1; ma = 64'(QOne - t_ff); mb = 64'(t_ff);
            ret_in = S_M4; state_in = S_MUL;
         end
         S_M4: begin
            mstart = 1'b1; ma = q_ff; mb = mprod;
            ret_in = S_M5; state_in = S_MUL;
         end
         S_M5: begin
            // keep lin*mt*t, start t*t
            r_in = mprod;
            mstart = 1'b1; ma = 64'(t_ff); mb = 64'(t_ff);
            ret_in = S_M6; state_in = S_MUL;
         end
         S_M6: begin
            // t^3 scaled by 2^16
            mstart = 1'b1; ma = mprod; mb = 64'({t_ff, 16'd0});
            ret_in = S_OUT; state_in = S_MUL;
         end
         S_OUT: begin
            if (!rsp_valid_ff || (rsp.ready)) begin
               rsp_in.segment_index = cur_ff;
               rsp_in.progress = act_ff ? 17'((r_ff + mprod) >> 48) : '0;
               rsp_in.active = act_ff;
               rsp_in.finished = cur_ff >= eff_count;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_MUL: begin
            // multiplier wait: the product is ready when done pulses
            if (mdone) state_in = ret_ff;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in; d_ff <= d_in; q_ff <= q_in; x_ff <= x_in; t_ff <= t_in;
      now_ff <= now_in; step_ff <= step_in; rsp_ff <= rsp_in; ret_ff <= ret_in;
      ent_ff <= table_mem[cur_in[IdxBits-1:0]];
      if (req.valid && req.ready && req.data.cmd == CMD_LOAD) begin
         table_mem[req.data.entry_index] <= '{
            duration: req.data.entry_duration,
            repeats:  req.data.entry_repeats,
            ease_in:  (req.data.entry_ease_in > QOne) ? QOne : req.data.entry_ease_in,
            ease_out: (req.data.entry_ease_out > QOne) ? QOne : req.data.entry_ease_out,
            moves:    req.data.entry_moves};
      end
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; cur_ff <= '0; start_ff <= '0;
         act_ff <= 1'b0; rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; cur_ff <= cur_in;
         start_ff <= start_in; act_ff <= act_in; rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |-> !rsp_valid_ff) else $error("request taken while response held");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid) else $error("response dropped");
   a_idx: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.data.segment_index <= CntBits'(MaxSegments))) else $error("index range");
`endif
endmodule
`default_nettype wire

@@ rtl/core/ess_serial_mul.sv @@
// Shift-and-add multiplier, one multiplier bit per cycle, 64-bit product.
// Depends on nothing.
`default_nettype none
module ess_serial_mul (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] op_a,
   input  wire logic [63:0] op_b,
   output logic             done,
   output logic [63:0]      product
);
   logic [63:0] a_ff, a_in, b_ff, b_in, p_ff, p_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;

   always_comb begin
      a_in = a_ff; b_in = b_ff; p_in = p_ff; busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         a_in = op_a; b_in = op_b; p_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff[0]) p_in = p_ff + a_ff;
         a_in = a_ff << 1;
         b_in = b_ff >> 1;
         if ((b_ff >> 1) == 64'd0) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in; b_ff <= b_in; p_ff <= p_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign product = p_ff;
endmodule
`default_nettype wire
